/* hdl/stf_pkg.sv */
// ----------------------------------------------------------------------------
// stf_pkg: shared types, constants and fixed-point helpers
// Word format, pipeline latencies and the saturating Q-format arithmetic that
// the friction pipeline and its tangent projection units share.
// ----------------------------------------------------------------------------
`default_nettype none

package stf_pkg;

    // word format
    localparam int DW   = 32;
    localparam int FRAC = 24;
    localparam int W2   = 2 * DW;

    typedef logic signed [DW-1:0] t_word;
    typedef t_word [2:0]          t_vec3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'b1;

    localparam logic [DW-2:0] EPS_RESET  = (DW-1)'(16777);
    localparam logic [DW-2:0] STEP_RESET = (DW-1)'(167772);

    // rounding and saturation constants
    localparam logic [W2-1:0] HALF    = W2'(1) << (FRAC - 1);
    localparam logic [W2-1:0] MAG_MAX = (W2'(1) << (DW - 1)) - W2'(1);
    localparam logic [DW-2:0] E_MAX   = '1;

    // squared gradient limit 1.21 in Q(2*FRAC)
    localparam logic [W2-1:0] FAULT_THR = (W2'(121) << (2 * FRAC)) / W2'(100);

    // division by three: x * RECIP3 >> RECIP3_SH is exact below 2^32
    localparam logic [DW-1:0] RECIP3    = 32'hAAAA_AAAB;
    localparam int            RECIP3_SH = DW + 1;

    // latencies of the iterative units
    localparam int TAN_LAT  = 4;
    localparam int SQRT_LAT = DW;
    localparam int DIV_LAT  = DW + 1;

    // magnitude of a signed word
    function automatic logic [DW-1:0] mag(input t_word a);
        logic [DW-1:0] u;
        u = a;
        return a[DW-1] ? (~u + DW'(1)) : u;
    endfunction

    // signed word from a magnitude, saturating
    function automatic t_word sat_mag(input logic [W2-1:0] m, input logic neg);
        logic [DW-1:0] lo;
        lo = m[DW-1:0];
        if (!neg) begin
            return (m > MAG_MAX) ? t_word'(MAG_MAX[DW-1:0]) : t_word'(lo);
        end
        if (m > MAG_MAX) begin
            return t_word'({1'b1, {(DW-1){1'b0}}});
        end
        return t_word'(~lo + DW'(1));
    endfunction

    // fixed-point product, rounded half away from zero, saturating
    function automatic t_word fmul(input t_word a, input t_word b);
        logic [W2-1:0] p;
        logic          neg;
        p   = W2'(mag(a)) * W2'(mag(b)) + HALF;
        neg = a[DW-1] ^ b[DW-1];
        return sat_mag(p >> FRAC, neg);
    endfunction

    // saturating add
    function automatic t_word sadd(input t_word a, input t_word b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? t_word'({1'b1, {(DW-1){1'b0}}}) : t_word'({1'b0, {(DW-1){1'b1}}});
        end
        return t_word'(s[DW-1:0]);
    endfunction

    // saturating subtract
    function automatic t_word ssub(input t_word a, input t_word b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? t_word'({1'b1, {(DW-1){1'b0}}}) : t_word'({1'b0, {(DW-1){1'b1}}});
        end
        return t_word'(s[DW-1:0]);
    endfunction

endpackage

`default_nettype wire

/* hdl/stf_tangent.sv */
// ----------------------------------------------------------------------------
// stf_tangent: tangent-plane projection v - n (n . v)
// Four register stages: products, dot sum, scaled normal, subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module stf_tangent import stf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_vec3 i_n,
    input  t_vec3 i_v,
    output t_vec3 o_v
);

    t_vec3 r_prod, r_n1, r_v1;
    t_word r_p;
    t_vec3 r_n2, r_v2;
    t_vec3 r_np, r_v3;
    t_vec3 r_out;

    // form the component products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= fmul(i_n[i], i_v[i]);
            end
            r_n1 <= i_n;
            r_v1 <= i_v;
        end
    end

    // sum into the dot product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= sadd(sadd(r_prod[0], r_prod[1]), r_prod[2]);
            r_n2 <= r_n1;
            r_v2 <= r_v1;
        end
    end

    // scale the normal by the dot product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_np[i] <= fmul(r_n2[i], r_p);
            end
            r_v3 <= r_v2;
        end
    end

    // remove the normal part
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= ssub(r_v3[i], r_np[i]);
            end
        end
    end

    assign o_v = r_out;

endmodule

`default_nettype wire

/* hdl/stf_sqrt.sv */
// ----------------------------------------------------------------------------
// stf_sqrt: pipelined integer square root
// One result bit per stage; gives the floor of the root of a double word.
// ----------------------------------------------------------------------------
`default_nettype none

module stf_sqrt import stf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W2-1:0] i_rad,
    output logic [DW-1:0] o_root
);

    logic [W2-1:0] r_op  [SQRT_LAT];
    logic [W2-1:0] r_res [SQRT_LAT];

    for (genvar s = 0; s < SQRT_LAT; s++) begin : g_step
        localparam logic [W2-1:0] ONE = W2'(1) << (W2 - 2 - 2 * s);
        logic [W2-1:0] w_op;
        logic [W2-1:0] w_res;
        logic [W2-1:0] w_trial;

        if (s == 0) begin : g_first
            assign w_op  = i_rad;
            assign w_res = '0;
        end else begin : g_next
            assign w_op  = r_op[s-1];
            assign w_res = r_res[s-1];
        end

        assign w_trial = w_res + ONE;

        // try the next root bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_op >= w_trial) begin
                    r_op[s]  <= w_op - w_trial;
                    r_res[s] <= (w_res >> 1) + ONE;
                end else begin
                    r_op[s]  <= w_op;
                    r_res[s] <= w_res >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_LAT-1][DW-1:0];

endmodule

`default_nettype wire

/* hdl/stf_div.sv */
// ----------------------------------------------------------------------------
// stf_div: pipelined restoring divider
// Double-word numerator over a word divisor; one quotient bit per stage.
// A quotient that does not fit in a word reads as all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module stf_div import stf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W2-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [DW-1:0] o_quo
);

    logic [DW-1:0] r_rem [DIV_LAT];
    logic [DW-1:0] r_low [DIV_LAT];
    logic [DW-1:0] r_den [DIV_LAT];
    logic [DW-1:0] r_q   [DIV_LAT];
    logic          r_ovf [DIV_LAT];

    // load the upper half and flag overflow
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[W2-1:DW];
            r_low[0] <= i_num[DW-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= i_num[W2-1:DW] >= i_den;
        end
    end

    for (genvar s = 1; s < DIV_LAT; s++) begin : g_step
        logic [DW:0] w_rem2;
        logic [DW:0] w_dif;
        logic        w_ge;

        assign w_rem2 = {r_rem[s-1], r_low[s-1][DW-1]};
        assign w_dif  = w_rem2 - {1'b0, r_den[s-1]};
        assign w_ge   = w_rem2 >= {1'b0, r_den[s-1]};

        // subtract where the divisor fits
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_dif[DW-1:0] : w_rem2[DW-1:0];
                r_low[s] <= r_low[s-1] << 1;
                r_den[s] <= r_den[s-1];
                r_q[s]   <= {r_q[s-1][DW-2:0], w_ge};
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_quo = r_ovf[DIV_LAT-1] ? '1 : r_q[DIV_LAT-1];

endmodule

`default_nettype wire

/* hdl/smoothed_tangential_friction.sv */
// ----------------------------------------------------------------------------
// smoothed_tangential_friction: mollified friction potential and gradient
// Projects a contact displacement onto the tangent plane and returns the
// smoothed friction energy, its tangential gradient and a fault flag.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output side does not stall and
// returns one result per request, in order. The pipeline depth is set by the
// square root (one bit per stage, 32 stages) and two dividers in series (33
// stages each); everything else is a few stages of multiply and add. A stall
// at the output holds the whole pipeline. The smoothing product eps * step is
// registered in the cycle after a register write.
`default_nettype none

module smoothed_tangential_friction import stf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_word                i_pos_x,
    input  t_word                i_pos_y,
    input  t_word                i_pos_z,
    input  t_word                i_prev_x,
    input  t_word                i_prev_y,
    input  t_word                i_prev_z,
    input  t_word                i_normal_x,
    input  t_word                i_normal_y,
    input  t_word                i_normal_z,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DW-2:0]        i_cfg_data,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DW-2:0]        o_energy,
    output t_word                o_grad_x,
    output t_word                o_grad_y,
    output t_word                o_grad_z,
    output logic                 o_fault
);

    // stage positions
    localparam int ST_R    = TAN_LAT;
    localparam int ST_SUM  = ST_R + 2;
    localparam int ST_ROOT = ST_SUM + SQRT_LAT;
    localparam int ST_PREP = ST_ROOT + 1;
    localparam int ST_T    = ST_PREP + DIV_LAT;
    localparam int ST_E1   = ST_T + 1;
    localparam int ST_Q    = ST_E1 + DIV_LAT;
    localparam int ST_X    = ST_Q + 1;
    localparam int ST_OUT  = ST_X + TAN_LAT;
    localparam int NSTG    = ST_OUT + 1;
    localparam int R_DLY   = ST_T - ST_R;
    localparam int N_DLY   = ST_X;

    localparam logic [FRAC+1:0] TWO_Q  = (FRAC+2)'(1) << (FRAC + 1);
    localparam logic [DW-1:0]   T_MAX  = DW'(1) << FRAC;
    localparam t_word           GR_HI  = t_word'(DW'(1) << FRAC);
    localparam t_word           GR_LO  = t_word'(DW'(0) - (DW'(1) << FRAC));

    typedef struct packed {
        logic [DW-2:0] d;
        logic          lt;
    } t_side_prep;

    typedef struct packed {
        logic [DW-2:0] d;
        logic          lt;
        logic          dz;
        logic [DW-1:0] a;
        logic [FRAC:0] t;
        logic [2:0]    rsgn;
    } t_side_e1;

    logic             w_en;
    logic [NSTG-1:0]  r_vld;

    logic [DW-2:0]    r_eps, r_step, r_k;
    t_word            w_k;

    t_vec3            w_pos, w_prev, w_nrm;
    t_vec3            r_diff0, r_nrm0;
    t_vec3            r_ndly [N_DLY];
    t_vec3            w_r;
    t_vec3            r_rdly [R_DLY];

    logic [W2-1:0]    r_sq [3];
    logic [W2-1:0]    r_sum;
    logic [DW-1:0]    w_root;
    logic [DW-2:0]    w_d;

    t_side_prep       r_prep;
    t_side_prep       r_pdly [DIV_LAT];
    logic [W2-1:0]    r_num1;
    logic [DW-1:0]    r_den1;
    logic [DW-1:0]    w_t;

    t_side_prep       w_pe;
    t_vec3            w_rr;
    logic [FRAC:0]    w_t25;
    logic [FRAC+1:0]  w_u;
    logic [W2-1:0]    w_aprod;
    logic [W2-1:0]    w_num2 [3];
    logic [DW-1:0]    w_den2;
    logic [W2-1:0]    r_num2 [3];
    logic [DW-1:0]    r_den2;
    t_side_e1         r_e1;
    t_side_e1         r_edly [DIV_LAT];
    logic [DW-1:0]    w_q [3];

    t_side_e1         w_xe;
    t_side_e1         r_xe;
    t_vec3            r_gr;
    t_vec3            w_g;

    logic [DW-1:0]    r_b;
    logic [W2-1:0]    r_sqg [3];
    t_side_e1         r_t1;
    logic [DW-2:0]    w_kb;
    logic [W2-1:0]    r_m;
    logic [W2-1:0]    r_sumg;
    t_side_e1         r_t2;
    logic [DW-2:0]    w_q3;
    logic [DW:0]      w_esum;
    logic [DW-2:0]    w_e;
    logic [DW-2:0]    r_e3, r_e4;
    logic             r_f3, r_f4;

    // global advance: the output register frees or drains
    assign w_en    = !r_vld[ST_OUT] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[ST_OUT];

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps  <= EPS_RESET;
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EPS:  r_eps  <= i_cfg_data;
                REG_STEP: r_step <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // smoothing width k = eps * step
    assign w_k = fmul(t_word'({1'b0, r_eps}), t_word'({1'b0, r_step}));

    always_ff @(posedge i_clk) begin
        r_k <= w_k[DW-2:0];
    end

    // displacement
    assign w_pos  = {i_pos_z, i_pos_y, i_pos_x};
    assign w_prev = {i_prev_z, i_prev_y, i_prev_x};
    assign w_nrm  = {i_normal_z, i_normal_y, i_normal_x};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_diff0[i] <= ssub(w_pos[i], w_prev[i]);
            end
            r_nrm0 <= w_nrm;
        end
    end

    // carry the normal to the second projection
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ndly[0] <= r_nrm0;
            for (int j = 1; j < N_DLY; j++) begin
                r_ndly[j] <= r_ndly[j-1];
            end
        end
    end

    stf_tangent u_tan_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   (r_nrm0),
        .i_v   (r_diff0),
        .o_v   (w_r)
    );

    // carry the tangent displacement to the gradient dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rdly[0] <= w_r;
            for (int j = 1; j < R_DLY; j++) begin
                r_rdly[j] <= r_rdly[j-1];
            end
        end
    end

    // squared length of r
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= W2'(mag(w_r[i])) * W2'(mag(w_r[i]));
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    stf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sum),
        .o_root (w_root)
    );

    // clamp d, choose branch, set up t = d / k
    assign w_d = w_root[DW-1] ? '1 : w_root[DW-2:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prep.d  <= w_d;
            r_prep.lt <= w_d < r_k;
            r_num1    <= (W2'(w_d) << FRAC) + W2'(r_k >> 1);
            r_den1    <= {1'b0, r_k};
        end
    end

    stf_div u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num1),
        .i_den (r_den1),
        .o_quo (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pdly[0] <= r_prep;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_pdly[j] <= r_pdly[j-1];
            end
        end
    end

    // a = d * t and the gradient numerators
    assign w_pe    = r_pdly[DIV_LAT-1];
    assign w_rr    = r_rdly[R_DLY-1];
    assign w_t25   = w_t[FRAC:0];
    assign w_u     = TWO_Q - {1'b0, w_t25};
    assign w_aprod = W2'(w_pe.d) * W2'(w_t25) + HALF;
    assign w_den2  = w_pe.lt ? {1'b0, r_k} : {1'b0, w_pe.d};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_pe.lt) begin
                w_num2[i] = W2'(mag(w_rr[i])) * W2'(w_u) + W2'(r_k >> 1);
            end else begin
                w_num2[i] = (W2'(mag(w_rr[i])) << FRAC) + W2'(w_pe.d >> 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num2[i]     <= w_num2[i];
                r_e1.rsgn[i]  <= w_rr[i][DW-1];
            end
            r_den2  <= w_den2;
            r_e1.d  <= w_pe.d;
            r_e1.lt <= w_pe.lt;
            r_e1.dz <= w_pe.d == '0;
            r_e1.a  <= w_aprod[FRAC +: DW];
            r_e1.t  <= w_t25;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        stf_div u_div_g (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num2[g]),
            .i_den (r_den2),
            .o_quo (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_edly[0] <= r_e1;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_edly[j] <= r_edly[j-1];
            end
        end
    end

    // signed gradient before projection; zero length gives zero
    assign w_xe = r_edly[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_gr[i] <= w_xe.dz ? '0 : sat_mag(W2'(w_q[i]), w_xe.rsgn[i]);
            end
            r_xe <= w_xe;
        end
    end

    stf_tangent u_tan_g (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   (r_ndly[N_DLY-1]),
        .i_v   (r_gr),
        .o_v   (w_g)
    );

    // energy: b = a * t, then a + (k - b) / 3 below k, else d; fault: squared gradient length
    assign w_kb   = ({1'b0, r_k} > r_b) ? (r_k - r_b[DW-2:0]) : '0;
    assign w_q3   = r_m[RECIP3_SH +: (DW-1)];
    assign w_esum = (DW+1)'(r_t2.a) + (DW+1)'(w_q3);
    assign w_e    = !r_t2.lt ? r_t2.d :
                    (w_esum > (DW+1)'(E_MAX)) ? E_MAX : w_esum[DW-2:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b  <= DW'((W2'(r_xe.a) * W2'(r_xe.t) + HALF) >> FRAC);
            for (int i = 0; i < 3; i++) begin
                r_sqg[i] <= W2'(mag(r_gr[i])) * W2'(mag(r_gr[i]));
            end
            r_t1 <= r_xe;

            r_m    <= W2'(DW'({1'b0, w_kb}) + DW'(1)) * W2'(RECIP3);
            r_sumg <= r_sqg[0] + r_sqg[1] + r_sqg[2];
            r_t2   <= r_t1;

            r_e3 <= w_e;
            r_f3 <= r_sumg > FAULT_THR;

            r_e4 <= r_e3;
            r_f4 <= r_f3;
        end
    end

    assign o_energy = r_e4;
    assign o_grad_x = w_g[0];
    assign o_grad_y = w_g[1];
    assign o_grad_z = w_g[2];
    assign o_fault  = r_f4;

    // below k the ratio t never exceeds one
    a_t_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_T] && w_pe.lt |-> w_t <= T_MAX)
        else $error("t above one in the cubic branch");

    // at or above k each gradient component is at most one
    a_gr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_X] && !r_xe.lt |->
            $signed(r_gr[0]) <= GR_HI && $signed(r_gr[0]) >= GR_LO &&
            $signed(r_gr[1]) <= GR_HI && $signed(r_gr[1]) >= GR_LO &&
            $signed(r_gr[2]) <= GR_HI && $signed(r_gr[2]) >= GR_LO)
        else $error("unit gradient component out of range");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
